>>> hdl/bir_pkg.sv
package bir_pkg;

  // Default sizes of the image store and the blend precision.
  localparam int unsigned MAX_SRC_WIDTH_DEF  = 128;
  localparam int unsigned MAX_SRC_HEIGHT_DEF = 128;
  localparam int unsigned MAX_PLANES_DEF     = 4;
  localparam int unsigned FRACTION_BITS_DEF  = 8;

  // Largest target size that the size registers are clamped to.
  localparam int unsigned MAX_DST_SIZE = 1024;

  // Field and register widths.
  localparam int unsigned POS_W      = 10;
  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SRC_SIZE_W = 8;
  localparam int unsigned DST_SIZE_W = 11;
  localparam int unsigned NC_W       = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // Fixed-point scale and coordinate arithmetic.
  localparam int unsigned Q_FRAC  = 16;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned PROD_W  = SCALE_W + POS_W + 1;
  localparam int unsigned IP_W    = PROD_W - 1 - Q_FRAC;
  localparam int unsigned NUM_W   = SRC_SIZE_W + Q_FRAC + 1;
  localparam int unsigned DEN_W   = DST_SIZE_W;

  // Request codes.
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_RESAMPLE = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [PLANE_W-1:0] plane;
    logic [PIX_W-1:0]   pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic [POS_W-1:0]   out_column;
    logic [POS_W-1:0]   out_row;
    logic [PLANE_W-1:0] out_plane;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [2:0] {
    SCL_START_H,
    SCL_WAIT_H,
    SCL_START_V,
    SCL_WAIT_V,
    SCL_IDLE
  } scl_state_e;

endpackage

>>> hdl/bir_stream_if.sv
interface bir_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/bir_div.sv
module bir_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bir_pkg::NUM_W-1:0] num_i,
  input  logic [bir_pkg::DEN_W-1:0] den_i,
  output bir_pkg::div_status_t      status_o,
  output logic [bir_pkg::NUM_W-1:0] quot_o
);
  import bir_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rem_q, acc_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = acc_q;
endmodule

>>> hdl/bilinear_image_resize.sv
// Bilinear image resizer. Load beats (req_type 0) write one 8-bit source pixel into the
// on-chip image store, which holds MAX_PLANES planes of MAX_SRC_HEIGHT rows of
// MAX_SRC_WIDTH pixels; loads outside the store are dropped. Resample beats
// (req_type 1) return one blended pixel for a destination column, row and plane;
// requests outside the target image or beyond the channel count give no result.
// The store is a single-port memory, so a load occupies it for one access and a
// resample for four accesses (one per neighbor); loads therefore flow at one beat per
// cycle unless a stalled output or a scale update holds them, and a resample holds the
// store until its four reads are issued. After reset and after every write to a size
// register the scale factors are recomputed by a serial divider, one axis after the
// other, and no input beat is taken until both are done. The store is not cleared by
// reset: a pixel read before it is written returns an undefined value.
module bilinear_image_resize #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int unsigned MAX_PLANES     = bir_pkg::MAX_PLANES_DEF,
  parameter int unsigned FRACTION_BITS  = bir_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bir_stream_if.sink                     in_i,
  bir_stream_if.source                   out_o
);
  import bir_pkg::*;

  localparam int unsigned F        = FRACTION_BITS;
  localparam int unsigned PLANE_SZ = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned DEPTH    = PLANE_SZ * MAX_PLANES;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned XW       = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW       = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned SW_W     = $clog2(MAX_SRC_WIDTH + 1);
  localparam int unsigned SH_W     = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int unsigned TOP_W    = PIX_W + F;
  localparam int unsigned SUM_W    = PIX_W + 2 * F;

  typedef struct packed {
    logic [IP_W-1:0] ip;
    logic [F-1:0]    fp;
  } axis_t;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    int unsigned r;
    r = v;
    if (v < 1) begin
      r = 1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // Source coordinate of one axis from the product scale*(2d+1), clamped.
  function automatic axis_t map_axis(logic [PROD_W-1:0] prod, logic [IP_W-1:0] last);
    axis_t             r;
    logic [PROD_W-1:0] pos;
    logic [IP_W-1:0]   ipart;
    pos   = prod - PROD_W'(1 << Q_FRAC);
    ipart = pos[PROD_W-1 -: IP_W];
    r     = '0;
    if (prod < PROD_W'(1 << Q_FRAC)) begin
      r = '0;
    end else if (ipart >= last) begin
      r.ip = last;
    end else begin
      r.ip = ipart;
      r.fp = pos[Q_FRAC -: F];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [SRC_SIZE_W-1:0] src_w_q, src_h_q;
  logic [DST_SIZE_W-1:0] dst_w_q, dst_h_q;
  logic [NC_W-1:0]       nc_q;
  logic                  size_wr;

  assign size_wr = cfg_we_i && (cfg_idx_i == CFG_SRC_WIDTH || cfg_idx_i == CFG_SRC_HEIGHT ||
                                cfg_idx_i == CFG_DST_WIDTH || cfg_idx_i == CFG_DST_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_SIZE_W'(128);
      src_h_q <= SRC_SIZE_W'(128);
      dst_w_q <= DST_SIZE_W'(128);
      dst_h_q <= DST_SIZE_W'(128);
      nc_q    <= NC_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[SRC_SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[SRC_SIZE_W-1:0];
        CFG_DST_WIDTH:  dst_w_q <= cfg_data_i[DST_SIZE_W-1:0];
        CFG_DST_HEIGHT: dst_h_q <= cfg_data_i[DST_SIZE_W-1:0];
        CFG_CHANNELS:   nc_q    <= cfg_data_i[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes.
  logic [SW_W-1:0]       sw;
  logic [SH_W-1:0]       sh;
  logic [DST_SIZE_W-1:0] tw, th;
  logic [NC_W:0]         nc;

  assign sw = SW_W'(clamp_size(int'(src_w_q), MAX_SRC_WIDTH));
  assign sh = SH_W'(clamp_size(int'(src_h_q), MAX_SRC_HEIGHT));
  assign tw = DST_SIZE_W'(clamp_size(int'(dst_w_q), MAX_DST_SIZE));
  assign th = DST_SIZE_W'(clamp_size(int'(dst_h_q), MAX_DST_SIZE));
  assign nc = (NC_W + 1)'(clamp_size(int'(nc_q), MAX_PLANES));

  // ---------------------------------------------------------------------------
  // Scale sequencer: horizontal then vertical through one shared divider.
  scl_state_e        scl_q, scl_d;
  logic [SCALE_W-1:0] scale_h_q, scale_h_d, scale_v_q, scale_v_d;
  logic              div_start;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den;
  div_status_t       div_st;
  logic [SCALE_W-1:0] quot_sat;

  assign quot_sat = (div_quot > NUM_W'({SCALE_W{1'b1}})) ? {SCALE_W{1'b1}}
                                                         : div_quot[SCALE_W-1:0];

  always_comb begin
    scl_d     = scl_q;
    scale_h_d = scale_h_q;
    scale_v_d = scale_v_q;
    div_start = 1'b0;
    div_num   = NUM_W'({sw, {Q_FRAC{1'b0}}}) + NUM_W'(tw >> 1);
    div_den   = tw;
    case (scl_q)
      SCL_START_H: begin
        div_start = 1'b1;
        scl_d     = SCL_WAIT_H;
      end
      SCL_WAIT_H: begin
        if (div_st.done) begin
          scale_h_d = quot_sat;
          scl_d     = SCL_START_V;
        end
      end
      SCL_START_V: begin
        div_start = 1'b1;
        div_num   = NUM_W'({sh, {Q_FRAC{1'b0}}}) + NUM_W'(th >> 1);
        div_den   = th;
        scl_d     = SCL_WAIT_V;
      end
      SCL_WAIT_V: begin
        if (div_st.done) begin
          scale_v_d = quot_sat;
          scl_d     = SCL_IDLE;
        end
      end
      SCL_IDLE: ;
      default: scl_d = SCL_START_H;
    endcase
    if (size_wr) begin
      scl_d = SCL_START_H;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q     <= SCL_START_H;
      scale_h_q <= '0;
      scale_v_q <= '0;
    end else begin
      scl_q     <= scl_d;
      scale_h_q <= scale_h_d;
      scale_v_q <= scale_v_d;
    end
  end

  bir_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_st),
    .quot_o   (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Pipeline handshake.
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q, b1_v_q, out_v_q;
  logic s0_ready, s1_ready, s2_ready, s3_ready, b1_ready, out_ready;
  logic s2_done, issue_ok, stuck, s3_load;
  logic rd_v_q;
  logic [1:0] rd_ph_q, ph_q;

  assign out_ready = !out_v_q || out_o.ready;
  assign b1_ready  = !b1_v_q || out_ready;
  assign s3_ready  = !s3_v_q || b1_ready;
  assign stuck     = rd_v_q && rd_ph_q == 2'd3 && !s3_ready;
  assign issue_ok  = s2_v_q && !stuck;
  assign s3_load   = rd_v_q && rd_ph_q == 2'd3 && s3_ready;
  assign s2_ready  = !s2_v_q || s2_done;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign s0_ready  = !s0_v_q || s1_ready;
  assign in_i.ready = s0_ready && scl_q == SCL_IDLE;

  // Stage 0: input register and range checks.
  in_beat_t s0_q;
  logic     s0_keep;

  always_comb begin
    if (s0_q.req_type == REQ_LOAD) begin
      s0_keep = int'(s0_q.column) < MAX_SRC_WIDTH && int'(s0_q.row) < MAX_SRC_HEIGHT &&
                int'(s0_q.plane) < MAX_PLANES;
    end else begin
      s0_keep = DST_SIZE_W'(s0_q.column) < tw && DST_SIZE_W'(s0_q.row) < th &&
                (NC_W + 1)'(s0_q.plane) < nc;
    end
  end

  // Stage 1: coordinate products and load address.
  logic               s1_type_q;
  logic [PROD_W-1:0]  s1_px_q, s1_py_q;
  logic [POS_W-1:0]   s1_col_q, s1_row_q;
  logic [PLANE_W-1:0] s1_pl_q;
  logic [PIX_W-1:0]   s1_pix_q;
  logic [ADDR_W-1:0]  s1_addr_q;

  // Stage 2: mapped coordinates; owns the store port.
  logic               s2_type_q;
  logic [XW-1:0]      s2_x0_q, s2_x1_q;
  logic [YW-1:0]      s2_y0_q, s2_y1_q;
  logic [F-1:0]       s2_fx_q, s2_fy_q;
  logic [POS_W-1:0]   s2_col_q, s2_row_q;
  logic [PLANE_W-1:0] s2_pl_q;
  logic [PIX_W-1:0]   s2_pix_q;
  logic [ADDR_W-1:0]  s2_addr_q;

  axis_t           mx, my;
  logic [XW-1:0]   mx0;
  logic [YW-1:0]   my0;

  assign mx  = map_axis(s1_px_q, IP_W'(sw - 1'b1));
  assign my  = map_axis(s1_py_q, IP_W'(sh - 1'b1));
  assign mx0 = mx.ip[XW-1:0];
  assign my0 = my.ip[YW-1:0];

  assign s2_done = issue_ok && (s2_type_q == REQ_LOAD || ph_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      if (s0_ready) begin
        s0_v_q <= in_i.valid && in_i.ready;
      end
      if (s1_ready) begin
        s1_v_q <= s0_v_q && s0_keep;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (issue_ok && s2_type_q == REQ_RESAMPLE) begin
        ph_q <= ph_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_q <= in_i.data;
    end
    if (s1_ready) begin
      s1_type_q <= s0_q.req_type;
      s1_px_q   <= PROD_W'(scale_h_q) * PROD_W'({s0_q.column, 1'b1});
      s1_py_q   <= PROD_W'(scale_v_q) * PROD_W'({s0_q.row, 1'b1});
      s1_col_q  <= s0_q.column;
      s1_row_q  <= s0_q.row;
      s1_pl_q   <= s0_q.plane;
      s1_pix_q  <= s0_q.pixel_in;
      s1_addr_q <= ADDR_W'(int'(s0_q.plane) * PLANE_SZ + int'(s0_q.row) * MAX_SRC_WIDTH +
                           int'(s0_q.column));
    end
    if (s2_ready) begin
      s2_type_q <= s1_type_q;
      s2_x0_q   <= mx0;
      s2_x1_q   <= (SW_W'(mx0) == SW_W'(sw - 1'b1)) ? mx0 : XW'(mx0 + 1'b1);
      s2_y0_q   <= my0;
      s2_y1_q   <= (SH_W'(my0) == SH_W'(sh - 1'b1)) ? my0 : YW'(my0 + 1'b1);
      s2_fx_q   <= mx.fp;
      s2_fy_q   <= my.fp;
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
      s2_pl_q   <= s1_pl_q;
      s2_pix_q  <= s1_pix_q;
      s2_addr_q <= s1_addr_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Image store: one access per cycle, read data registered.
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [XW-1:0]     xsel;
  logic [YW-1:0]     ysel;

  assign mem_we = issue_ok && s2_type_q == REQ_LOAD;
  assign mem_re = issue_ok && s2_type_q == REQ_RESAMPLE;

  // Neighbor order: top left, top right, bottom left, bottom right.
  always_comb begin
    xsel = ph_q[0] ? s2_x1_q : s2_x0_q;
    ysel = ph_q[1] ? s2_y1_q : s2_y0_q;
    if (s2_type_q == REQ_LOAD) begin
      mem_addr = s2_addr_q;
    end else begin
      mem_addr = ADDR_W'(int'(s2_pl_q) * PLANE_SZ + int'(ysel) * MAX_SRC_WIDTH + int'(xsel));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= s2_pix_q;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Read tracking; a last-neighbor beat waits in the read register while stage 3 is full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      rd_ph_q <= '0;
    end else begin
      rd_v_q <= mem_re || stuck;
      if (mem_re) begin
        rd_ph_q <= ph_q;
      end
    end
  end

  // Neighbor capture and request tags held for the last read.
  logic [PIX_W-1:0]   cap_q [3];
  logic [F-1:0]       rm_fx_q, rm_fy_q;
  logic [POS_W-1:0]   rm_col_q, rm_row_q;
  logic [PLANE_W-1:0] rm_pl_q;

  always_ff @(posedge clk_i) begin
    if (rd_v_q && rd_ph_q != 2'd3) begin
      cap_q[rd_ph_q] <= rdata_q;
    end
    if (mem_re && ph_q == 2'd3) begin
      rm_fx_q  <= s2_fx_q;
      rm_fy_q  <= s2_fy_q;
      rm_col_q <= s2_col_q;
      rm_row_q <= s2_row_q;
      rm_pl_q  <= s2_pl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3, horizontal blend and vertical blend with rounding.
  logic [PIX_W-1:0]   s3_p_q [4];
  logic [F-1:0]       s3_fx_q, s3_fy_q, b1_fy_q;
  logic [POS_W-1:0]   s3_col_q, s3_row_q, b1_col_q, b1_row_q;
  logic [PLANE_W-1:0] s3_pl_q, b1_pl_q;
  logic [TOP_W-1:0]   b1_top_q, b1_bot_q;
  out_beat_t          out_q;
  logic [F:0]         omfx, omfy;
  logic [SUM_W-1:0]   sum;

  assign omfx = {1'b1, {F{1'b0}}} - (F + 1)'(s3_fx_q);
  assign omfy = {1'b1, {F{1'b0}}} - (F + 1)'(b1_fy_q);
  assign sum  = SUM_W'(b1_top_q) * SUM_W'(omfy) + SUM_W'(b1_bot_q) * SUM_W'(b1_fy_q) +
                (SUM_W'(1) << (2 * F - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q  <= 1'b0;
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_v_q <= s3_load;
      end
      if (b1_ready) begin
        b1_v_q <= s3_v_q;
      end
      if (out_ready) begin
        out_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      s3_p_q[0] <= cap_q[0];
      s3_p_q[1] <= cap_q[1];
      s3_p_q[2] <= cap_q[2];
      s3_p_q[3] <= rdata_q;
      s3_fx_q   <= rm_fx_q;
      s3_fy_q   <= rm_fy_q;
      s3_col_q  <= rm_col_q;
      s3_row_q  <= rm_row_q;
      s3_pl_q   <= rm_pl_q;
    end
    if (b1_ready) begin
      b1_top_q <= TOP_W'(TOP_W'(s3_p_q[0]) * TOP_W'(omfx) + TOP_W'(s3_p_q[1]) * TOP_W'(s3_fx_q));
      b1_bot_q <= TOP_W'(TOP_W'(s3_p_q[2]) * TOP_W'(omfx) + TOP_W'(s3_p_q[3]) * TOP_W'(s3_fx_q));
      b1_fy_q  <= s3_fy_q;
      b1_col_q <= s3_col_q;
      b1_row_q <= s3_row_q;
      b1_pl_q  <= s3_pl_q;
    end
    if (out_ready) begin
      out_q.pixel_out  <= sum[SUM_W-1 -: PIX_W];
      out_q.out_column <= b1_col_q;
      out_q.out_row    <= b1_row_q;
      out_q.out_plane  <= b1_pl_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  // A last-neighbor beat that cannot move on keeps its data and blocks the store.
  a_stuck_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck |=> rd_v_q && rd_ph_q == 2'd3 && $stable(rdata_q))
    else $error("last neighbor read lost while stage 3 was full");

  a_stuck_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck |-> !mem_we && !mem_re)
    else $error("store accessed while a read beat was waiting");

  // No input beat is taken while the scale factors are being recomputed.
  a_no_accept_scaling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !(in_i.valid && in_i.ready))
    else $error("input beat accepted during scale update");
`endif
endmodule

>>> tb/sv/bilinear_image_resize_tb.sv
`timescale 1ns / 1ps

module bilinear_image_resize_tb;
  import bir_pkg::*;

  localparam int unsigned SW_MAX     = MAX_SRC_WIDTH_DEF;
  localparam int unsigned SH_MAX     = MAX_SRC_HEIGHT_DEF;
  localparam int unsigned PL_MAX     = MAX_PLANES_DEF;
  localparam int unsigned FB         = FRACTION_BITS_DEF;
  localparam int unsigned STORE_SIZE = SW_MAX * SH_MAX * PL_MAX;
  localparam int unsigned SETTLE     = 24;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  bir_stream_if #(.payload_t(in_beat_t)) pix_in_if ();
  bir_stream_if #(.payload_t(out_beat_t)) pix_out_if ();

  bilinear_image_resize dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pix_in_if.sink),
    .out_o      (pix_out_if.source)
  );

  // Shadow copy of the image store and of the size registers.
  logic [7:0] image_mirror [STORE_SIZE];
  bit written_mask [STORE_SIZE];
  int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg, planes_reg;
  int unsigned h_scale, v_scale;

  out_beat_t pending_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit idle_en = 1'b1;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always #4 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned scale_of(int unsigned src, int unsigned dst);
    longint unsigned q;
    q = ((longint'(src) << 16) + (dst >> 1)) / dst;
    return (q > 64'hFFFFFF) ? 32'hFFFFFF : int'(q);
  endfunction

  function automatic void refresh_scales();
    h_scale = scale_of(clamp_size(src_w_reg, SW_MAX), clamp_size(dst_w_reg, MAX_DST_SIZE));
    v_scale = scale_of(clamp_size(src_h_reg, SH_MAX), clamp_size(dst_h_reg, MAX_DST_SIZE));
  endfunction

  // Destination index to source integer position and fraction, clamped to the image.
  function automatic void map_coord(int unsigned scl, int unsigned d, int unsigned size,
                                    output int unsigned ip, output int unsigned fp);
    longint p;
    longint unsigned up;
    p = longint'(scl) * longint'(2 * d + 1) - 65536;
    ip = 0;
    fp = 0;
    if (p >= 0) begin
      up = longint'(p) >> 1;
      if ((up >> 16) >= size - 1) begin
        ip = size - 1;
      end else begin
        ip = int'(up >> 16);
        fp = int'((up & 64'hFFFF) >> (16 - FB));
      end
    end
  endfunction

  function automatic int unsigned store_index(int unsigned pl, int unsigned y, int unsigned x);
    return (pl * SH_MAX + y) * SW_MAX + x;
  endfunction

  // Works out whether a resample beat gives a pixel, and which one.
  // all_known reports whether the four neighbors were loaded.
  function automatic bit resample_pixel(in_beat_t b, output logic [7:0] pix,
                                        output bit all_known);
    int unsigned sw, sh, x0, x1, y0, y1, fx, fy;
    longint unsigned one, top, bot, acc;
    sw = clamp_size(src_w_reg, SW_MAX);
    sh = clamp_size(src_h_reg, SH_MAX);
    pix = '0;
    all_known = 1'b1;
    if (b.column >= clamp_size(dst_w_reg, MAX_DST_SIZE) ||
        b.row >= clamp_size(dst_h_reg, MAX_DST_SIZE) ||
        b.plane >= clamp_size(planes_reg, PL_MAX)) return 1'b0;
    map_coord(h_scale, b.column, sw, x0, fx);
    map_coord(v_scale, b.row, sh, y0, fy);
    x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
    y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
    all_known = written_mask[store_index(b.plane, y0, x0)] &&
                written_mask[store_index(b.plane, y0, x1)] &&
                written_mask[store_index(b.plane, y1, x0)] &&
                written_mask[store_index(b.plane, y1, x1)];
    one = 1 << FB;
    top = image_mirror[store_index(b.plane, y0, x0)] * (one - fx) +
          image_mirror[store_index(b.plane, y0, x1)] * fx;
    bot = image_mirror[store_index(b.plane, y1, x0)] * (one - fx) +
          image_mirror[store_index(b.plane, y1, x1)] * fx;
    acc = (top * (one - fy) + bot * fy + (1 << (2 * FB - 1))) >> (2 * FB);
    pix = (acc > 255) ? 8'hFF : acc[7:0];
    return 1'b1;
  endfunction

  function automatic in_beat_t make_beat(logic kind, int unsigned col, int unsigned row,
                                         int unsigned pl, int unsigned pix);
    in_beat_t b;
    b.req_type = kind;
    b.column = col[POS_W-1:0];
    b.row = row[POS_W-1:0];
    b.plane = pl[PLANE_W-1:0];
    b.pixel_in = pix[PIX_W-1:0];
    return b;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Offers one beat, after an optional idle burst, and updates the shadow state once it
  // is taken. Valid stays high on return so back-to-back beats never drop it.
  // Resamples that would touch unloaded pixels are not sent.
  task automatic send_beat(in_beat_t b);
    logic [7:0] pix;
    bit known;
    bit gives;
    out_beat_t o;
    if (b.req_type == REQ_RESAMPLE) begin
      gives = resample_pixel(b, pix, known);
      if (gives && !known) return;
    end
    if (idle_en && $urandom_range(0, 4) == 0) begin
      pix_in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.data <= b;
    do @(posedge clk_i); while (!(pix_in_if.valid && pix_in_if.ready));
    if (b.req_type == REQ_LOAD) begin
      if (b.column < SW_MAX && b.row < SH_MAX && b.plane < PL_MAX) begin
        image_mirror[store_index(b.plane, b.row, b.column)] = b.pixel_in;
        written_mask[store_index(b.plane, b.row, b.column)] = 1'b1;
      end
    end else if (resample_pixel(b, pix, known)) begin
      o.pixel_out = pix;
      o.out_column = b.column;
      o.out_row = b.row;
      o.out_plane = b.plane;
      pending_pixels.push_back(o);
    end
  endtask

  // Drops valid and waits until every pixel is back and the block has gone quiet.
  task automatic drain();
    pix_in_if.valid <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  src_w_reg = val & 8'hFF;
      CFG_SRC_HEIGHT: src_h_reg = val & 8'hFF;
      CFG_DST_WIDTH:  dst_w_reg = val & 11'h7FF;
      CFG_DST_HEIGHT: dst_h_reg = val & 11'h7FF;
      CFG_CHANNELS:   planes_reg = val & 3'h7;
      default: ;
    endcase
    refresh_scales();
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th, int unsigned nc);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, tw);
    write_reg(CFG_DST_HEIGHT, th);
    write_reg(CFG_CHANNELS, nc);
  endtask

  // Loads every pixel of the active image with random values.
  task automatic load_image();
    int unsigned sw, sh, nc;
    sw = clamp_size(src_w_reg, SW_MAX);
    sh = clamp_size(src_h_reg, SH_MAX);
    nc = clamp_size(planes_reg, PL_MAX);
    for (int p = 0; p < nc; p++)
      for (int y = 0; y < sh; y++)
        for (int x = 0; x < sw; x++)
          send_beat(make_beat(REQ_LOAD, x, y, p, $urandom_range(0, 255)));
  endtask

  task automatic random_request();
    send_beat(make_beat(REQ_RESAMPLE,
                        $urandom_range(0, clamp_size(dst_w_reg, MAX_DST_SIZE) - 1),
                        $urandom_range(0, clamp_size(dst_h_reg, MAX_DST_SIZE) - 1),
                        $urandom_range(0, clamp_size(planes_reg, PL_MAX) - 1),
                        $urandom_range(0, 255)));
  endtask

  // Output side: ready with random stall bursts and a long hold when asked.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      pix_out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      pix_out_if.ready <= 1'b0;
    end else begin
      pix_out_if.ready <= 1'b1;
    end
  end

  // Each output beat is checked against the oldest expected pixel.
  always @(posedge clk_i) begin
    out_beat_t want;
    out_beat_t got;
    if (rst_ni && pix_out_if.valid && pix_out_if.ready) begin
      got = pix_out_if.data;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat, column", got.out_column, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_out !== want.pixel_out)
          report_mismatch("pixel_out", got.pixel_out, want.pixel_out);
        if (got.out_column !== want.out_column)
          report_mismatch("out_column", got.out_column, want.out_column);
        if (got.out_row !== want.out_row)
          report_mismatch("out_row", got.out_row, want.out_row);
        if (got.out_plane !== want.out_plane)
          report_mismatch("out_plane", got.out_plane, want.out_plane);
      end
    end
  end

  // Field extremes, image corners, every plane and the dropped cases.
  task automatic test_directed();
    set_geometry(4, 3, 7, 5, 4);
    load_image();
    send_beat(make_beat(REQ_LOAD, 0, 0, 0, 255));
    send_beat(make_beat(REQ_LOAD, 3, 2, 3, 0));
    // Loads outside the store are dropped.
    send_beat(make_beat(REQ_LOAD, 1023, 0, 0, 8'hAA));
    send_beat(make_beat(REQ_LOAD, 0, 1023, 1, 8'h55));
    send_beat(make_beat(REQ_LOAD, 128, 128, 2, 8'hFF));
    for (int p = 0; p < 4; p++) begin
      send_beat(make_beat(REQ_RESAMPLE, 0, 0, p, 8'hFF));
      send_beat(make_beat(REQ_RESAMPLE, 6, 4, p, 0));
    end
    send_beat(make_beat(REQ_RESAMPLE, 3, 2, 1, 0));
    send_beat(make_beat(REQ_RESAMPLE, 6, 0, 2, 0));
    send_beat(make_beat(REQ_RESAMPLE, 0, 4, 3, 0));
    // Requests outside the target image give nothing.
    send_beat(make_beat(REQ_RESAMPLE, 1023, 0, 0, 0));
    send_beat(make_beat(REQ_RESAMPLE, 0, 1023, 0, 0));
    send_beat(make_beat(REQ_RESAMPLE, 7, 5, 0, 0));
    write_reg(CFG_CHANNELS, 3);
    send_beat(make_beat(REQ_RESAMPLE, 2, 2, 3, 0));
    send_beat(make_beat(REQ_RESAMPLE, 2, 2, 2, 0));
  endtask

  // Largest and smallest sizes, and register values that saturate.
  task automatic test_size_extremes();
    set_geometry(128, 1, 1024, 1, 1);
    load_image();
    repeat (60) random_request();
    send_beat(make_beat(REQ_RESAMPLE, 1023, 0, 0, 0));
    set_geometry(1, 128, 1, 1024, 1);
    load_image();
    repeat (60) random_request();
    send_beat(make_beat(REQ_RESAMPLE, 0, 1023, 0, 0));
    // Zero sizes clamp to one, oversize values clamp to the maxima.
    set_geometry(0, 0, 2047, 0, 7);
    load_image();
    repeat (20) random_request();
    set_geometry(255, 200, 0, 2047, 0);
    send_beat(make_beat(REQ_RESAMPLE, 0, 0, 0, 0));
    send_beat(make_beat(REQ_RESAMPLE, 0, 1023, 0, 0));
    send_beat(make_beat(REQ_RESAMPLE, 0, 500, 1, 0));
    set_geometry(2, 2, 1024, 1024, 4);
    load_image();
    repeat (30) random_request();
  endtask

  // Random geometry per phase, mostly valid requests with some noise.
  task automatic test_random_resize(int unsigned phases, int unsigned beats);
    int unsigned pick;
    for (int ph = 0; ph < phases; ph++) begin
      set_geometry($urandom_range(1, 12), $urandom_range(1, 12),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 40),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 40),
                   $urandom_range(1, 4));
      load_image();
      for (int n = 0; n < beats; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          random_request();
        else if (pick < 90)
          send_beat(make_beat(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 3),
                              $urandom_range(0, 255)));
        else
          send_beat(make_beat(REQ_LOAD,
                              $urandom_range(0, clamp_size(src_w_reg, SW_MAX) - 1),
                              $urandom_range(0, clamp_size(src_h_reg, SH_MAX) - 1),
                              $urandom_range(0, clamp_size(planes_reg, PL_MAX) - 1),
                              $urandom_range(0, 255)));
      end
    end
  endtask

  // Output held off long enough that the block fills up and stops taking beats.
  task automatic test_backpressure();
    set_geometry(5, 4, 17, 9, 2);
    load_image();
    drain();
    hold_left = 300;
    repeat (40) random_request();
    drain();
  endtask

  initial begin
    pix_in_if.valid = 1'b0;
    pix_in_if.data = '0;
    pix_out_if.ready = 1'b0;
    src_w_reg = 128;
    src_h_reg = 128;
    dst_w_reg = 128;
    dst_h_reg = 128;
    planes_reg = 3;
    refresh_scales();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_size_extremes();
    test_random_resize(5, 50);
    test_backpressure();
    idle_en = 1'b0;
    test_random_resize(2, 50);
    drain();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
